/* hdl/frcr_pkg.sv */
// ----------------------------------------------------------------------------
// frcr_pkg - shared constants and helpers for the framed request checker
// Register indexes, frame positions and the ASCII hex conversions.
// ----------------------------------------------------------------------------
package frcr_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_HEADER     = 3'd0;
	localparam logic [2:0] REG_FOOTER     = 3'd1;
	localparam logic [2:0] REG_TYPE_LOW   = 3'd2;
	localparam logic [2:0] REG_TYPE_HIGH  = 3'd3;
	localparam logic [2:0] REG_ACK_CODE   = 3'd4;
	localparam logic [2:0] REG_ERROR_CODE = 3'd5;

	// frame byte positions
	localparam logic [2:0] POS_HEADER  = 3'd0;
	localparam logic [2:0] POS_TYPE    = 3'd1;
	localparam logic [2:0] POS_FOOTER  = 3'd2;
	localparam logic [2:0] POS_CSUM_HI = 3'd3;
	localparam logic [2:0] POS_CSUM_LO = 3'd4;

	// reply length in bytes
	localparam logic [2:0] REPLY_LEN = 3'd5;

	// register reset values
	localparam logic [7:0] HEADER_RST     = 8'h02;
	localparam logic [7:0] FOOTER_RST     = 8'h03;
	localparam logic [7:0] TYPE_LOW_RST   = 8'h01;
	localparam logic [7:0] TYPE_HIGH_RST  = 8'h04;
	localparam logic [7:0] ACK_CODE_RST   = 8'h05;
	localparam logic [7:0] ERROR_CODE_RST = 8'h06;

	// decode one ASCII hex character; non-hex characters still map to a nibble
	function automatic logic [3:0] hex_char_value(input logic [7:0] c);
		logic [7:0] v;
		if (c <= 8'h39) begin
			v = c;
		end else if (c <= 8'h46) begin
			v = c - 8'h37;
		end else begin
			v = c - 8'h57;
		end
		return v[3:0];
	endfunction

	// encode one nibble as an upper-case ASCII hex character
	function automatic logic [7:0] nibble_char(input logic [3:0] n);
		logic [7:0] r;
		if (n >= 4'd10) begin
			r = {4'd0, n} + 8'd55;
		end else begin
			r = {4'd0, n} | 8'h30;
		end
		return r;
	endfunction

endpackage

/* hdl/framed_request_checker_and_reply.sv */
// ----------------------------------------------------------------------------
// framed_request_checker_and_reply - five-byte request checker with reply
// Checks header, type range, footer and hex checksum; sends a five-byte reply.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter on the s_* stream, one item per byte. Every five
//   bytes form a frame: header, type, footer, checksum high and low hex
//   characters. The fifth byte of a frame produces five reply items on the
//   m_* stream: header, ack or error code, footer and two upper-case hex
//   characters of (header + footer + code) mod 256; m_tlast marks the fifth.
//   Bytes 0..3 of a frame produce no item.
//   Flow: an input item lands in the input register, is checked there, and
//   the fifth byte of a frame loads the reply buffer once it is free; each
//   reply item then moves into the output register that drives m_*.
//   Throughput: one input item per cycle while no reply is draining. The
//   single reply buffer holds the fifth byte of the next frame back until
//   its five items have moved into the output register, one per cycle.
//   A stalled receiver (m_tready low) holds the output register, which in
//   turn holds the reply buffer; the first four bytes of a new frame are
//   still taken meanwhile.
//   Reset clears the frame position, checks, reply buffer and output valid
//   and loads the default register values. Write configuration through
//   cfg_we/cfg_index/cfg_data only while the block is idle; writes to an
//   index beyond the list are ignored.
// ----------------------------------------------------------------------------
module framed_request_checker_and_reply (
	input  logic       clk,
	input  logic       arst_n,
	// receive stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	// reply stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] tx_byte
	output logic       m_tlast,   // reply_last
	// configuration write port
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import frcr_pkg::*;

	// configuration registers
	logic [7:0] header_q, footer_q, type_low_q, type_high_q, ack_code_q, error_code_q;

	// input register
	logic       rx_valid_s1;
	logic [7:0] rx_s1;

	// frame state
	logic [2:0] pos_q;
	logic [7:0] sum_q;
	logic       bad_q;
	logic [3:0] upper_q;

	// reply buffer
	logic [2:0] reply_idx_q;   // reply bytes still to move into the output register
	logic [7:0] rep_header_q, rep_code_q, rep_footer_q, rep_sum_q;

	// control
	logic       is_final;
	logic       consume;
	logic       out_load;
	logic [7:0] recv;
	logic [7:0] code;
	logic [7:0] reply_sum;
	logic [7:0] out_byte;

	// the final frame byte needs a free reply buffer; other bytes pass freely
	assign is_final = pos_q[2];
	assign consume  = rx_valid_s1 && (!is_final || (reply_idx_q == 3'd0));
	assign s_tready = !rx_valid_s1 || consume;
	assign out_load = (reply_idx_q != 3'd0) && (!m_tvalid || m_tready);

	// checksum compare and reply code
	assign recv      = {upper_q, hex_char_value(rx_s1)};
	assign code      = (bad_q || (recv != sum_q)) ? error_code_q : ack_code_q;
	assign reply_sum = header_q + footer_q + code;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q     <= HEADER_RST;
			footer_q     <= FOOTER_RST;
			type_low_q   <= TYPE_LOW_RST;
			type_high_q  <= TYPE_HIGH_RST;
			ack_code_q   <= ACK_CODE_RST;
			error_code_q <= ERROR_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER:     header_q     <= cfg_data;
				REG_FOOTER:     footer_q     <= cfg_data;
				REG_TYPE_LOW:   type_low_q   <= cfg_data;
				REG_TYPE_HIGH:  type_high_q  <= cfg_data;
				REG_ACK_CODE:   ack_code_q   <= cfg_data;
				REG_ERROR_CODE: error_code_q <= cfg_data;
				default: ;   // drop writes beyond the list
			endcase
		end
	end

	// input register: hold while the final byte waits for the reply buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			rx_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rx_s1 <= s_tdata;
		end
	end

	// frame checks, one byte per consume
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_HEADER;
			sum_q   <= 8'd0;
			bad_q   <= 1'b0;
			upper_q <= 4'd0;
		end else if (consume) begin
			case (pos_q)
				POS_HEADER: begin
					sum_q <= rx_s1;
					bad_q <= (rx_s1 != header_q);
					pos_q <= POS_TYPE;
				end
				POS_TYPE: begin
					sum_q <= sum_q + rx_s1;
					if ((rx_s1 < type_low_q) || (rx_s1 > type_high_q)) begin
						bad_q <= 1'b1;
					end
					pos_q <= POS_FOOTER;
				end
				POS_FOOTER: begin
					sum_q <= sum_q + rx_s1;
					if (rx_s1 != footer_q) begin
						bad_q <= 1'b1;
					end
					pos_q <= POS_CSUM_HI;
				end
				POS_CSUM_HI: begin
					upper_q <= hex_char_value(rx_s1);
					pos_q   <= POS_CSUM_LO;
				end
				default: begin
					// last byte: start a fresh frame
					pos_q   <= POS_HEADER;
					sum_q   <= 8'd0;
					bad_q   <= 1'b0;
					upper_q <= 4'd0;
				end
			endcase
		end
	end

	// reply buffer: load on the final byte, count down as items leave
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_idx_q <= 3'd0;
		end else if (consume && is_final) begin
			reply_idx_q <= REPLY_LEN;
		end else if (out_load) begin
			reply_idx_q <= reply_idx_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && is_final) begin
			rep_header_q <= header_q;
			rep_code_q   <= code;
			rep_footer_q <= footer_q;
			rep_sum_q    <= reply_sum;
		end
	end

	// pick the reply byte for the current count
	always_comb begin
		case (reply_idx_q)
			3'd5:    out_byte = rep_header_q;
			3'd4:    out_byte = rep_code_q;
			3'd3:    out_byte = rep_footer_q;
			3'd2:    out_byte = nibble_char(rep_sum_q[7:4]);
			3'd1:    out_byte = nibble_char(rep_sum_q[3:0]);
			default: out_byte = 8'd0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= out_byte;
			m_tlast <= (reply_idx_q == 3'd1);
		end
	end

	// ---- assertions ----
	a_reply_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		reply_idx_q <= REPLY_LEN)
		else $error("reply count out of range");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_CSUM_LO)
		else $error("frame position out of range");

	a_final_loads_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && is_final) |=> (reply_idx_q == REPLY_LEN) && (pos_q == POS_HEADER))
		else $error("final byte did not start a full reply");

	a_last_on_fifth: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (reply_idx_q == 3'd1)) |=> (m_tvalid && m_tlast))
		else $error("fifth reply item not marked last");

endmodule

/* test/frcr_reply_checker.sv */
// ----------------------------------------------------------------------------
// frcr_reply_checker - scoreboard for the framed request checker
// Watches the receive, reply and configuration ports, predicts the reply
// items of every frame and compares them with what the block sends.
// ----------------------------------------------------------------------------
module frcr_reply_checker
	import frcr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tlast,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int         failures,
	output int         pending
);

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       reply_last;
	} reply_item_t;

	reply_item_t replies_due[$];
	int          fail_count = 0;
	int          due_count  = 0;

	// shadow registers
	logic [7:0] hdr_reg, ftr_reg, tlo_reg, thi_reg, ack_reg, err_reg;

	// frame tracking
	logic [2:0] frame_pos;
	logic [7:0] run_sum;
	logic       frame_failed;
	logic [3:0] csum_high;

	assign failures = fail_count;
	assign pending  = due_count;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	function automatic logic [3:0] decode_csum_char(input logic [7:0] c);
		logic [7:0] d;
		d = (c <= 8'h39) ? c : ((c <= 8'h46) ? c - 8'h37 : c - 8'h57);
		return d[3:0];
	endfunction

	function automatic logic [7:0] encode_nibble(input logic [3:0] n);
		return (n > 4'd9) ? 8'h37 + {4'd0, n} : 8'h30 + {4'd0, n};
	endfunction

	task automatic absorb_rx_byte(input logic [7:0] b);
		logic [7:0] rcv_csum;
		logic [7:0] code;
		logic [7:0] reply_sum;
		case (frame_pos)
			POS_HEADER: begin
				run_sum      = b;
				frame_failed = (b != hdr_reg);
				frame_pos    = POS_TYPE;
			end
			POS_TYPE: begin
				run_sum = run_sum + b;
				if (b < tlo_reg || b > thi_reg) begin
					frame_failed = 1'b1;
				end
				frame_pos = POS_FOOTER;
			end
			POS_FOOTER: begin
				run_sum = run_sum + b;
				if (b != ftr_reg) begin
					frame_failed = 1'b1;
				end
				frame_pos = POS_CSUM_HI;
			end
			POS_CSUM_HI: begin
				csum_high = decode_csum_char(b);
				frame_pos = POS_CSUM_LO;
			end
			default: begin
				rcv_csum  = {csum_high, decode_csum_char(b)};
				code      = (frame_failed || rcv_csum != run_sum) ? err_reg : ack_reg;
				reply_sum = hdr_reg + ftr_reg + code;
				replies_due.push_back({hdr_reg, 1'b0});
				replies_due.push_back({code, 1'b0});
				replies_due.push_back({ftr_reg, 1'b0});
				replies_due.push_back({encode_nibble(reply_sum[7:4]), 1'b0});
				replies_due.push_back({encode_nibble(reply_sum[3:0]), 1'b1});
				frame_pos    = POS_HEADER;
				run_sum      = 8'd0;
				frame_failed = 1'b0;
				csum_high    = 4'd0;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_item_t want;
		if (!arst_n) begin
			hdr_reg      = HEADER_RST;
			ftr_reg      = FOOTER_RST;
			tlo_reg      = TYPE_LOW_RST;
			thi_reg      = TYPE_HIGH_RST;
			ack_reg      = ACK_CODE_RST;
			err_reg      = ERROR_CODE_RST;
			frame_pos    = POS_HEADER;
			run_sum      = 8'd0;
			frame_failed = 1'b0;
			csum_high    = 4'd0;
			replies_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (replies_due.size() == 0) begin
					report_mismatch($sformatf("reply item %h with nothing due", m_tdata));
				end else begin
					want = replies_due.pop_front();
					if (m_tdata !== want.tx_byte) begin
						report_mismatch($sformatf("tx_byte %h, want %h", m_tdata, want.tx_byte));
					end
					if (m_tlast !== want.reply_last) begin
						report_mismatch($sformatf("reply_last %b, want %b",
							m_tlast, want.reply_last));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				absorb_rx_byte(s_tdata);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_HEADER:     hdr_reg = cfg_data;
					REG_FOOTER:     ftr_reg = cfg_data;
					REG_TYPE_LOW:   tlo_reg = cfg_data;
					REG_TYPE_HIGH:  thi_reg = cfg_data;
					REG_ACK_CODE:   ack_reg = cfg_data;
					REG_ERROR_CODE: err_reg = cfg_data;
					default: ;
				endcase
			end
		end
		due_count = replies_due.size();
	end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb - testbench top for the framed request checker
// Drives directed and random request frames plus noise under changing
// register settings and idle patterns; the checker scores the reply items.
// ----------------------------------------------------------------------------
module tb;
	import frcr_pkg::*;

	// indexes past the register list; writes there must change nothing
	localparam logic [2:0] REG_UNUSED_A = 3'd6;
	localparam logic [2:0] REG_UNUSED_B = 3'd7;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata   = 8'd0;   // [7:0] rx_byte
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;            // [7:0] tx_byte
	logic       m_tlast;            // reply_last
	logic       cfg_we    = 1'b0;
	logic [2:0] cfg_index = 3'd0;
	logic [7:0] cfg_data  = 8'd0;

	int failures;
	int pending;

	// idle rates in percent of cycles
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;

	// stimulus-side copy of the settings, used to build well-formed frames
	logic [7:0] cur_hdr = HEADER_RST;
	logic [7:0] cur_ftr = FOOTER_RST;
	logic [7:0] cur_tlo = TYPE_LOW_RST;
	logic [7:0] cur_thi = TYPE_HIGH_RST;

	int bytes_sent    = 0;
	int pos_in_frame  = 0;

	framed_request_checker_and_reply dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	frcr_reply_checker scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.failures  (failures),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: stall at random, one decision per cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// hard stop well past the slowest legal run
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// offer one item, idling first at the sender's rate; return right after
	// the edge that accepted it, with tvalid still high
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do begin
			@(posedge clk);
		end while (!s_tready);
		bytes_sent++;
		pos_in_frame = (pos_in_frame + 1) % 5;
	endtask

	// pick one of the spellings that decode to this nibble, aliases included
	function automatic logic [7:0] csum_char(input logic [3:0] n);
		logic [7:0] v;
		case ($urandom_range(2))
			0: v = (n > 4'd9) ? 8'h37 + {4'd0, n} : 8'h30 + {4'd0, n};
			1: v = (n > 4'd9) ? 8'h57 + {4'd0, n} : {4'($urandom_range(3)), n};
			default: v = (n > 4'd9) ? 8'h57 + {4'd0, n} + {4'($urandom_range(9)), 4'd0}
			                        : 8'h30 + {4'd0, n};
		endcase
		return v;
	endfunction

	// one random unit: mostly well-formed frames, some with a single broken
	// field, the rest loose noise that shifts the framing
	task automatic send_request();
		logic [7:0] hb, ty, fb, sum;
		int roll;
		roll = $urandom_range(99);
		if (roll < 15) begin
			repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
		end else begin
			// drain any partial frame so the next five bytes line up
			while (pos_in_frame != 0) begin
				send_byte(8'($urandom));
			end
			hb = cur_hdr;
			fb = cur_ftr;
			ty = (cur_tlo <= cur_thi) ? 8'($urandom_range(cur_thi, cur_tlo)) : 8'($urandom);
			sum = 8'd0;
			if (roll < 40) begin
				case ($urandom_range(3))
					0: hb = 8'($urandom);
					1: ty = 8'($urandom);
					2: fb = 8'($urandom);
					default: sum = 8'($urandom_range(255, 1));
				endcase
			end
			sum = sum ^ (hb + ty + fb);
			send_byte(hb);
			send_byte(ty);
			send_byte(fb);
			send_byte(csum_char(sum[7:4]));
			send_byte(csum_char(sum[3:0]));
		end
	endtask

	// drop valid, wait for every due reply item, then give the input register
	// time to empty before registers change
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [2:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [7:0] h, input logic [7:0] f,
	                             input logic [7:0] lo, input logic [7:0] hi,
	                             input logic [7:0] ack, input logic [7:0] err);
		cfg_put(REG_HEADER, h);
		cfg_put(REG_FOOTER, f);
		cfg_put(REG_TYPE_LOW, lo);
		cfg_put(REG_TYPE_HIGH, hi);
		cfg_put(REG_ACK_CODE, ack);
		cfg_put(REG_ERROR_CODE, err);
		cfg_put(REG_UNUSED_A, 8'($urandom));
		cfg_put(REG_UNUSED_B, 8'($urandom));
		cfg_we  <= 1'b0;
		cur_hdr = h;
		cur_ftr = f;
		cur_tlo = lo;
		cur_thi = hi;
	endtask

	initial begin
		logic [7:0] directed [25];
		logic [7:0] lo;
		int phase_start;
		int phase;

		// reset defaults: header 02, footer 03, types 01..04
		directed = '{
			// clean frame, ack
			8'h02, 8'h01, 8'h03, 8'h30, 8'h36,
			// wrong header with a matching checksum still gets the error code
			8'h00, 8'h04, 8'h03, 8'h30, 8'h37,
			// type at the top of the byte range, outside 01..04
			8'h02, 8'hFF, 8'h03, 8'h30, 8'h34,
			// non-hex checksum characters that decode to a wrong value
			8'h02, 8'h03, 8'h03, 8'hFF, 8'h00,
			// non-hex characters that happen to decode to the right sum
			8'h02, 8'h03, 8'h03, 8'h10, 8'h5F
		};

		src_idle_pct  = 16;
		sink_idle_pct = 81;

		// hold reset, then release once
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_byte(directed[i]);
		end

		// three idle regimes, two register settings each
		for (int regime = 0; regime < 3; regime++) begin
			case (regime)
				0: begin
					src_idle_pct  = 16;
					sink_idle_pct = 81;
				end
				1: begin
					src_idle_pct  = 81;
					sink_idle_pct = 16;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int s = 0; s < 2; s++) begin
				phase = regime * 2 + s;
				settle();
				case (phase)
					// widest range, extreme codes
					0: load_settings(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF);
					// empty type range: every type fails
					1: load_settings(8'($urandom), 8'($urandom), 8'hC0, 8'h3F,
						8'($urandom), 8'($urandom));
					// single accepted type at the top
					2: load_settings(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
					default: begin
						lo = 8'($urandom);
						load_settings(8'($urandom), 8'($urandom), lo,
							8'($urandom_range(255, lo)), 8'($urandom), 8'($urandom));
					end
				endcase
				phase_start = bytes_sent;
				while (bytes_sent - phase_start < 42) begin
					send_request();
				end
			end
		end

		// drain: wait for every due item, then wait on for any stray items
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		if (failures == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/frcr_pkg.sv
hdl/framed_request_checker_and_reply.sv
test/frcr_reply_checker.sv
test/tb.sv
